// ===== rtl/ecal_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, result types and the month table of the calendar date unit.
package ecal_pkg;

  localparam int EPOCH_W = 32;
  localparam int OFFSET_W = 17;
  localparam int DAY_W = 16;
  localparam int REM_W = 17;
  localparam int OUT_TDATA_W = 40;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 17'd28800;

  localparam logic [15:0] RECIP_675 = 16'd49710;
  localparam logic [11:0] RECIP_60 = 12'd2184;
  localparam logic [5:0] RECIP_60_MIN = 6'd34;
  localparam logic [13:0] RECIP_7 = 14'd9362;
  localparam logic [5:0] RECIP_1461 = 6'd44;

  localparam logic [15:0] DAYS_EPOCH_TO_2001 = 16'd11323;
  localparam logic [17:0] DAYS_BORROWED = 18'd134774;
  localparam logic [17:0] DAYS_100Y = 18'd36524;
  localparam logic [11:0] DAYS_4Y = 12'd1461;
  localparam logic [10:0] DAYS_1Y = 11'd365;
  localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] dom;
    logic [2:0] weekday;
  } date_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } clock_t;

  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && (m >= 4'd2)) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

endpackage

// ===== rtl/ecal_clock.sv =====
`timescale 1ns / 1ps
// Seven-stage split of the second of the day into hour, minute and second.
module ecal_clock import ecal_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [REM_W-1:0] rem,
  output clock_t           result
);

  logic [27:0] p1;
  logic [REM_W-1:0] rem1;
  logic [10:0] q2;
  logic [6:0] r2;
  logic [10:0] mt3;
  logic [5:0] sec3;
  logic [15:0] p4;
  logic [10:0] mt4;
  logic [5:0] sec4;
  logic [4:0] hq5;
  logic [6:0] rm5;
  logic [5:0] sec5;
  logic [4:0] hour6;
  logic [5:0] min6;
  logic [5:0] sec6;

  logic [10:0] q_est;
  logic [6:0] r_est;
  logic [4:0] hq_est;
  logic [6:0] rm_est;

  always_comb begin
    q_est = p1[27:17];
    r_est = 7'(rem1 - 17'(17'(q_est) * 17'd60));
    hq_est = p4[15:11];
    rm_est = 7'(mt4 - 11'(11'(hq_est) * 11'd60));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= 28'(rem) * 28'(RECIP_60);
      rem1 <= rem;
      q2 <= q_est;
      r2 <= r_est;
      if (r2 >= 7'd60) begin
        mt3 <= q2 + 11'd1;
        sec3 <= 6'(r2 - 7'd60);
      end else begin
        mt3 <= q2;
        sec3 <= 6'(r2);
      end
      p4 <= 16'(mt3) * 16'(RECIP_60_MIN);
      mt4 <= mt3;
      sec4 <= sec3;
      hq5 <= hq_est;
      rm5 <= rm_est;
      sec5 <= sec4;
      if (rm5 >= 7'd60) begin
        hour6 <= hq5 + 5'd1;
        min6 <= 6'(rm5 - 7'd60);
      end else begin
        hour6 <= hq5;
        min6 <= 6'(rm5);
      end
      sec6 <= sec5;
      result.hour <= hour6;
      result.minute <= min6;
      result.second <= sec6;
    end
  end

endmodule

// ===== rtl/ecal_date.sv =====
`timescale 1ns / 1ps
// Seven-stage conversion of the day count into year, month, day and weekday.
module ecal_date import ecal_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DAY_W-1:0] day,
  output date_t            result
);

  logic [17:0] d1;
  logic [15:0] w1;
  logic [28:0] pw1;
  logic [15:0] d2;
  logic [1:0] n100_2;
  logic [3:0] r7_2;
  logic [20:0] p3;
  logic [15:0] d2_3;
  logic [1:0] n100_3;
  logic [2:0] wd3;
  logic [11:0] r4_4;
  logic [4:0] n4e_4;
  logic [1:0] n100_4;
  logic [2:0] wd4;
  logic [10:0] d3_5;
  logic [4:0] n4_5;
  logic [1:0] n100_5;
  logic [2:0] wd5;
  logic [8:0] d4_6;
  logic leap6;
  logic [6:0] yy6;
  logic [2:0] wd6;

  logic [15:0] w_sum;
  logic [1:0] n100;
  logic [17:0] base100;
  logic [12:0] q7;
  logic [3:0] r7_fix;
  logic [4:0] n4_est;
  logic [1:0] n1;
  logic [10:0] base1;
  logic [6:0] yy_sum;
  logic [3:0] mon;
  logic [8:0] mon_base;

  always_comb begin
    w_sum = day + EPOCH_WEEKDAY;
    if (d1 >= 18'd109572) begin
      n100 = 2'd3;
    end else if (d1 >= 18'd73048) begin
      n100 = 2'd2;
    end else if (d1 >= DAYS_100Y) begin
      n100 = 2'd1;
    end else begin
      n100 = 2'd0;
    end
    base100 = 18'(n100) * DAYS_100Y;
    q7 = pw1[28:16];
    r7_fix = (r7_2 >= 4'd7) ? r7_2 - 4'd7 : r7_2;
    n4_est = p3[20:16];
    if (d3_5 >= 11'd1095) begin
      n1 = 2'd3;
    end else if (d3_5 >= 11'd730) begin
      n1 = 2'd2;
    end else if (d3_5 >= DAYS_1Y) begin
      n1 = 2'd1;
    end else begin
      n1 = 2'd0;
    end
    base1 = 11'(n1) * DAYS_1Y;
    yy_sum = 7'd1 + 7'({n4_5, 2'b00}) + 7'(n1);
    mon = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (d4_6 >= month_start(4'(k), leap6)) begin
        mon = 4'(k);
      end
    end
    mon_base = month_start(mon, leap6);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (day >= DAYS_EPOCH_TO_2001) begin
        d1 <= 18'(day) - 18'(DAYS_EPOCH_TO_2001);
      end else begin
        d1 <= 18'(day) + DAYS_BORROWED;
      end
      w1 <= w_sum;
      pw1 <= 29'(w_sum) * 29'(RECIP_7);

      d2 <= 16'(d1 - base100);
      n100_2 <= n100;
      r7_2 <= 4'(w1 - 16'(16'(q7) * 16'd7));

      p3 <= 21'(d2) * 21'(RECIP_1461);
      d2_3 <= d2;
      n100_3 <= n100_2;
      wd3 <= (r7_fix == 4'd0) ? 3'd7 : 3'(r7_fix);

      r4_4 <= 12'(d2_3 - 16'(16'(n4_est) * 16'(DAYS_4Y)));
      n4e_4 <= n4_est;
      n100_4 <= n100_3;
      wd4 <= wd3;

      if (r4_4 >= DAYS_4Y) begin
        d3_5 <= 11'(r4_4 - DAYS_4Y);
        n4_5 <= n4e_4 + 5'd1;
      end else begin
        d3_5 <= 11'(r4_4);
        n4_5 <= n4e_4;
      end
      n100_5 <= n100_4;
      wd5 <= wd4;

      d4_6 <= 9'(d3_5 - base1);
      leap6 <= (n1 == 2'd3) && ((n4_5 != 5'd24) || (n100_5 == 2'd3));
      yy6 <= (yy_sum == 7'd100) ? 7'd0 : yy_sum;
      wd6 <= wd5;

      result.year <= yy6;
      result.month <= mon + 4'd1;
      result.dom <= 5'(d4_6 - mon_base + 9'd1);
      result.weekday <= wd6;
    end
  end

endmodule

// ===== rtl/epoch_seconds_to_calendar_date_unit.sv =====
`timescale 1ns / 1ps
// Top level of the epoch seconds to local calendar date and time converter.
//
//  Channel  Signals                      Contents
//  cfg      cfg_valid/cfg_ready/cfg_data  signed zone offset in seconds
//  s        s_tvalid/s_tready/s_tdata     one epoch seconds count per item
//  m        m_tvalid/m_tready/m_tdata     one date and time per item
//
// One item enters per cycle while the output is not stalled.
// The pipeline depth is set by the chain of reciprocal multiplies with correction.
// Reset empties the pipeline and loads an offset of 28800 seconds.
// A stalled output holds every stage; nothing is dropped or repeated.
module epoch_seconds_to_calendar_date_unit import ecal_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [OFFSET_W-1:0]    cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [EPOCH_W-1:0]     s_tdata,      // epoch_seconds
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata       // year, month, day, hour, minute, second, weekday
);

  localparam int Stages = 11;

  logic [OFFSET_W-1:0] zone_offset;
  logic [Stages-1:0] vld;
  logic en;

  logic [31:0] t_s1;
  logic [40:0] p_s2;
  logic [24:0] q1_s2;
  logic [6:0] lo_s2;
  logic [15:0] qe_s3;
  logic [10:0] r_s3;
  logic [6:0] lo_s3;
  logic [DAY_W-1:0] day_s4;
  logic [REM_W-1:0] rem_s4;

  logic [15:0] qe;
  logic [25:0] prod675;

  date_t date_out;
  clock_t clock_out;

  assign en = !vld[Stages-1] || m_tready;
  assign s_tready = en;
  assign cfg_ready = 1'b1;
  assign m_tvalid = vld[Stages-1];

  always_comb begin
    qe = p_s2[40:25];
    prod675 = 26'(qe) * 26'd675;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      zone_offset <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Stages-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_s1 <= s_tdata + {{(EPOCH_W-OFFSET_W){zone_offset[OFFSET_W-1]}}, zone_offset};
      p_s2 <= 41'(t_s1[31:7]) * 41'(RECIP_675);
      q1_s2 <= t_s1[31:7];
      lo_s2 <= t_s1[6:0];
      qe_s3 <= qe;
      r_s3 <= 11'(q1_s2 - prod675[24:0]);
      lo_s3 <= lo_s2;
      if (r_s3 >= 11'd675) begin
        day_s4 <= qe_s3 + 16'd1;
        rem_s4 <= {10'(r_s3 - 11'd675), lo_s3};
      end else begin
        day_s4 <= qe_s3;
        rem_s4 <= {r_s3[9:0], lo_s3};
      end
    end
  end

  ecal_date u_date (
    .clk    (clk),
    .en     (en),
    .day    (day_s4),
    .result (date_out)
  );

  ecal_clock u_clock (
    .clk    (clk),
    .en     (en),
    .rem    (rem_s4),
    .result (clock_out)
  );

  assign m_tdata = {4'b0000, date_out.weekday, clock_out.second, clock_out.minute,
                    clock_out.hour, date_out.dom, date_out.month, date_out.year};

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> rem_s4 < 17'd86400)
    else $error("second of day out of range");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> date_out.month >= 4'd1 && date_out.month <= 4'd12)
    else $error("month out of range");

  a_day_hour: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> date_out.dom >= 5'd1 && clock_out.hour <= 5'd23)
    else $error("day or hour out of range");

  a_min_sec_wd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> clock_out.minute <= 6'd59 && clock_out.second <= 6'd59 &&
                 date_out.weekday >= 3'd1 && date_out.weekday <= 3'd7 &&
                 date_out.year <= 7'd99)
    else $error("minute, second, weekday or year out of range");

endmodule

// ===== test/epoch_seconds_to_calendar_date_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the epoch seconds to calendar date unit.
module epoch_seconds_to_calendar_date_unit_tb;
  import ecal_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 110;
  localparam int LONG_HOLD = 200;
  localparam int HOLD_AFTER = 300;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } cal_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] zone;
    logic [EPOCH_W-1:0] epoch;
    logic known;
    cal_t want;
  } row_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    cal_t date;
  } pending_t;

  localparam cal_t NO_DATE = '0;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [OFFSET_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [EPOCH_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  pending_t pending_dates[$];
  logic [OFFSET_W-1:0] zone_model = OFFSET_RESET;
  int errors = 0;
  int dates_checked = 0;
  int items_sent = 0;
  int zones_written = 0;
  int burst_left = 0;
  int cycles = 0;

  // Directed items: offset extremes, wraparound on both sides, century and leap boundaries.
  row_t dir_rows [19] = '{
    '{17'd28800, 32'd0, 1'b1, '{7'd70, 4'd1, 5'd1, 5'd8, 6'd0, 6'd0, 3'd4}},
    '{17'd28800, 32'hFFFFFFFF, 1'b0, NO_DATE},
    '{17'd0, 32'd0, 1'b1, '{7'd70, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd4}},
    '{17'd0, 32'hFFFFFFFF, 1'b1, '{7'd6, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15, 3'd7}},
    '{17'd0, 32'd946684799, 1'b1, '{7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 3'd5}},
    '{17'd0, 32'd951782400, 1'b0, NO_DATE},
    '{17'd0, 32'd978220800, 1'b0, NO_DATE},
    '{17'd0, 32'd978307199, 1'b0, NO_DATE},
    '{17'd0, 32'd978307200, 1'b1, '{7'd1, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd1}},
    '{17'd0, 32'd1104451200, 1'b0, NO_DATE},
    '{17'd0, 32'd4107456000, 1'b0, NO_DATE},
    '{17'd0, 32'd4107542400, 1'b0, NO_DATE},
    '{-17'sd43200, 32'd0, 1'b0, NO_DATE},
    '{-17'sd43200, 32'd43199, 1'b0, NO_DATE},
    '{-17'sd43200, 32'd43200, 1'b0, NO_DATE},
    '{17'd50400, 32'hFFFFFFFF, 1'b0, NO_DATE},
    '{17'd50400, 32'd4294916895, 1'b0, NO_DATE},
    '{17'h10000, 32'd65535, 1'b0, NO_DATE},
    '{17'h10000, 32'd951868800, 1'b0, NO_DATE}
  };

  epoch_seconds_to_calendar_date_unit i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out with %0d dates still outstanding.", pending_dates.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic cal_t convert_epoch(logic [EPOCH_W-1:0] epoch, logic [OFFSET_W-1:0] zone);
    logic [31:0] t;
    logic [31:0] day_cnt;
    logic [31:0] rem_s;
    logic [31:0] wd;
    logic [31:0] d;
    logic [31:0] yr;
    logic [31:0] n;
    logic leap;
    int unsigned mlen [12];
    int m;
    cal_t c;
    t = epoch + {{(32 - OFFSET_W){zone[OFFSET_W-1]}}, zone};
    day_cnt = t / 32'd86400;
    rem_s = t % 32'd86400;
    wd = (day_cnt + 32'd4) % 32'd7;
    if (wd == 0) begin
      wd = 7;
    end
    if (day_cnt >= 32'd11323) begin
      d = day_cnt - 32'd11323;
      yr = 2001;
    end else begin
      d = day_cnt + 32'd146097 - 32'd11323;
      yr = 1601;
    end
    n = d / 32'd146097;
    yr = yr + 400 * n;
    d = d - 32'd146097 * n;
    n = d / 32'd36524;
    if (n > 3) begin
      n = 3;
    end
    yr = yr + 100 * n;
    d = d - 32'd36524 * n;
    n = d / 32'd1461;
    if (n > 24) begin
      n = 24;
    end
    yr = yr + 4 * n;
    d = d - 32'd1461 * n;
    n = d / 32'd365;
    if (n > 3) begin
      n = 3;
    end
    yr = yr + n;
    d = d - 32'd365 * n;
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    mlen = '{31, leap ? 29 : 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    m = 0;
    while (m < 12 && d >= mlen[m]) begin
      d = d - mlen[m];
      m++;
    end
    if (m > 11) begin
      m = 11;
    end
    c.year = 7'(yr % 100);
    c.month = 4'(m + 1);
    c.day = 5'(d + 1);
    c.hour = 5'(rem_s / 3600);
    c.minute = 6'((rem_s / 60) % 60);
    c.second = 6'(rem_s % 60);
    c.weekday = 3'(wd);
    return c;
  endfunction

  function automatic logic [EPOCH_W-1:0] pick_epoch();
    logic [31:0] day_start;
    day_start = $urandom_range(0, 49710) * 32'd86400;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom();
      5: return day_start;
      6: return day_start + 32'd86399;
      7: return day_start + $urandom_range(0, 86399);
      8: return $urandom_range(0, 100000);
      default: return 32'hFFFFFFFF - $urandom_range(0, 100000);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want,
                             logic [EPOCH_W-1:0] epoch);
    if (got != want) begin
      report_mismatch($sformatf("epoch %0d %s got %0d want %0d", epoch, name, got, want));
    end
  endtask

  // The result is sampled on the falling edge before the rising edge that accepts it.
  always @(negedge clk) begin
    cal_t got;
    pending_t head;
    if (!rst && m_tvalid && m_tready) begin
      got.year = m_tdata[6:0];
      got.month = m_tdata[10:7];
      got.day = m_tdata[15:11];
      got.hour = m_tdata[20:16];
      got.minute = m_tdata[26:21];
      got.second = m_tdata[32:27];
      got.weekday = m_tdata[35:33];
      if (pending_dates.size() == 0) begin
        report_mismatch($sformatf("unexpected date %h", m_tdata));
      end else begin
        head = pending_dates.pop_front();
        check_field("year", got.year, head.date.year, head.epoch);
        check_field("month", got.month, head.date.month, head.epoch);
        check_field("day", got.day, head.date.day, head.epoch);
        check_field("hour", got.hour, head.date.hour, head.epoch);
        check_field("minute", got.minute, head.date.minute, head.epoch);
        check_field("second", got.second, head.date.second, head.epoch);
        check_field("weekday", got.weekday, head.date.weekday, head.epoch);
        check_field("padding", m_tdata[OUT_TDATA_W-1:36], 0, head.epoch);
      end
      dates_checked++;
    end
  end

  // The receiver switches among random stall patterns and holds off once for long.
  initial begin
    int mode;
    int hold_left;
    bit held;
    mode = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!held && dates_checked >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = LONG_HOLD;
        m_tready <= 1'b0;
      end else begin
        if (cycles % 48 == 0) begin
          mode = $urandom_range(0, 3);
        end
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (cycles % 4 == 0);
          default: m_tready <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  task automatic push_epoch(logic [EPOCH_W-1:0] epoch, cal_t want);
    bit took;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= epoch;
    do begin
      @(negedge clk);
      took = s_tready;
      if (took) begin
        pending_dates.push_back('{epoch, want});
        items_sent++;
      end
      @(posedge clk);
    end while (!took);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_zone(logic [OFFSET_W-1:0] zone);
    bit took;
    cfg_valid <= 1'b1;
    cfg_data <= zone;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
    zone_model = zone;
    zones_written++;
  endtask

  initial begin
    logic [OFFSET_W-1:0] zone;
    logic [EPOCH_W-1:0] epoch;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].zone != zone_model) begin
        wait_idle();
        write_zone(dir_rows[i].zone);
      end
      push_epoch(dir_rows[i].epoch, dir_rows[i].known ? dir_rows[i].want :
                 convert_epoch(dir_rows[i].epoch, zone_model));
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: zone = 17'h0FFFF;
        1: zone = -17'sd43200;
        2: zone = 17'd50400;
        3: zone = 17'd0;
        default: zone = 17'($urandom_range(0, 93600) - 43200);
      endcase
      wait_idle();
      write_zone(zone);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        epoch = pick_epoch();
        push_epoch(epoch, convert_epoch(epoch, zone_model));
      end
    end

    wait_idle();
    $display("Sent %0d timestamps across %0d zone offset writes; %0d dates compared.",
             items_sent, zones_written, dates_checked);
    $display("Covered offset extremes, wraparound, leap days and the 2000 and 2100 boundaries.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ecal_pkg.sv
rtl/ecal_clock.sv
rtl/ecal_date.sv
rtl/epoch_seconds_to_calendar_date_unit.sv
test/epoch_seconds_to_calendar_date_unit_tb.sv
